[rtl/core/assert_macros.svh]
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is high.
`define SPQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sorted priority queue check failed");

// Check on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("sorted priority queue check failed");

`endif

[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue cells and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

   localparam int unsigned DataW   = 32;
   localparam int unsigned PrioW   = 16;
   localparam int unsigned StatusW = 2;
   localparam int unsigned OccW    = 5;

   localparam logic ACTION_ENQ = 1'b0;
   localparam logic ACTION_DEQ = 1'b1;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                    valid;
      logic signed [DataW-1:0] data;
      logic signed [PrioW-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                    enq;
      logic                    deq;
      logic signed [DataW-1:0] data;
      logic signed [PrioW-1:0] prio;
   } ctl_type;

endpackage

[rtl/core/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::ctl_type   ctl,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_keep,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               keep
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   assign keep  = entry_ff.valid && (entry_ff.prio >= ctl.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.enq) begin
         priority if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in.valid = 1'b1;
            entry_in.data  = ctl.data;
            entry_in.prio  = ctl.prio;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.deq) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.data <= entry_in.data;
      entry_ff.prio <= entry_in.prio;
   end

endmodule

[rtl/core/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Response: registered in the output register in the cycle after the request transaction.
// Throughput: one transaction per cycle while the response side is not stalled; all cells compare and shift together.
// Reset: clears all cell valid bits and the count; cell payloads are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [spq_pkg::DataW-1:0]    req_item_data,
   input  logic signed [spq_pkg::PrioW-1:0]    req_item_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [spq_pkg::StatusW-1:0]         rsp_status,
   output logic signed [spq_pkg::DataW-1:0]    rsp_out_data,
   output logic signed [spq_pkg::PrioW-1:0]    rsp_out_priority,
   output logic [spq_pkg::OccW-1:0]            rsp_occupancy
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);

   spq_pkg::entry_type cell_entry [DEPTH];
   logic [DEPTH-1:0]   keep_vec;
   logic [DEPTH-1:0]   valid_vec;
   spq_pkg::ctl_type   ctl;

   logic                             req_fire;
   logic                             full;
   logic                             empty;
   logic                             enq_ok;
   logic                             deq_ok;

   logic [CntW-1:0]                  count_ff;
   logic [CntW-1:0]                  count_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   spq_pkg::status_type              status_ff;
   spq_pkg::status_type              status_in;
   logic signed [spq_pkg::DataW-1:0] data_ff;
   logic signed [spq_pkg::DataW-1:0] data_in;
   logic signed [spq_pkg::PrioW-1:0] prio_ff;
   logic signed [spq_pkg::PrioW-1:0] prio_in;
   logic [CntW+spq_pkg::OccW-1:0]    occ_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = cell_entry[DEPTH-1].valid;
   assign empty     = !cell_entry[0].valid;
   assign enq_ok    = req_fire && (req_action == spq_pkg::ACTION_ENQ) && !full;
   assign deq_ok    = req_fire && (req_action == spq_pkg::ACTION_DEQ) && !empty;

   assign ctl.enq  = enq_ok;
   assign ctl.deq  = deq_ok;
   assign ctl.data = req_item_data;
   assign ctl.prio = req_item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_keep;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_keep  = keep_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (keep_vec[i])
      );

      assign valid_vec[i] = cell_entry[i].valid;
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      data_in      = data_ff;
      prio_in      = prio_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         data_in      = '0;
         prio_in      = '0;
         priority if (enq_ok) begin
            status_in = spq_pkg::STATUS_OK;
            count_in  = count_ff + 1'b1;
         end else if (deq_ok) begin
            status_in = spq_pkg::STATUS_OK;
            count_in  = count_ff - 1'b1;
            data_in   = cell_entry[0].data;
            prio_in   = cell_entry[0].prio;
         end else if (req_action == spq_pkg::ACTION_ENQ) begin
            status_in = spq_pkg::STATUS_FULL;
         end else begin
            status_in = spq_pkg::STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      prio_ff   <= prio_in;
   end

   assign occ_wide = {{spq_pkg::OccW{1'b0}}, count_ff};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_data     = data_ff;
   assign rsp_out_priority = prio_ff;
   assign rsp_occupancy    = occ_wide[spq_pkg::OccW-1:0];

   `SPQ_ASSERT(a_count_matches_cells, clock, reset, $countones(valid_vec) == count_ff)
   `SPQ_ASSERT(a_deq_shrinks, clock, reset, deq_ok |=> (count_ff == $past(count_ff) - 1'b1))
   `SPQ_ASSERT(a_front_sorted, clock, reset, valid_vec[1] |-> (cell_entry[0].prio >= cell_entry[1].prio))

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_priority_queue. A shadow copy of the sorted
// store predicts every response: insert behind all entries of greater or
// equal priority, pop the front, flag full and empty. Both channels stall at
// random, with one burst of back-to-back traffic and drain pauses in between.
// ----------------------------------------------------------------------------

class priority_queue_checker #(int Depth = 16);

   typedef struct {
      logic [spq_pkg::StatusW-1:0]      status;
      logic signed [spq_pkg::DataW-1:0] data;
      logic signed [spq_pkg::PrioW-1:0] prio;
      logic [spq_pkg::OccW-1:0]         occupancy;
   } outcome_type;

   logic signed [spq_pkg::DataW-1:0] held_data [Depth];
   logic signed [spq_pkg::PrioW-1:0] held_prio [Depth];
   int          held_count = 0;
   outcome_type awaited [$];
   int          mismatches = 0;

   function void note_request(logic action, logic signed [spq_pkg::DataW-1:0] data,
                              logic signed [spq_pkg::PrioW-1:0] prio);
      outcome_type want;
      int i;
      want.status = spq_pkg::STATUS_OK;
      want.data   = '0;
      want.prio   = '0;
      if (action == spq_pkg::ACTION_ENQ) begin
         if (held_count >= Depth) begin
            want.status = spq_pkg::STATUS_FULL;
         end else begin
            i = held_count;
            while (i > 0 && held_prio[i-1] < prio) begin
               held_data[i] = held_data[i-1];
               held_prio[i] = held_prio[i-1];
               i--;
            end
            held_data[i] = data;
            held_prio[i] = prio;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            want.status = spq_pkg::STATUS_EMPTY;
         end else begin
            want.data = held_data[0];
            want.prio = held_prio[0];
            for (i = 1; i < held_count; i++) begin
               held_data[i-1] = held_data[i];
               held_prio[i-1] = held_prio[i];
            end
            held_count--;
         end
      end
      want.occupancy = spq_pkg::OccW'(held_count);
      awaited.push_back(want);
   endfunction

   task report_mismatch(string msg);
      if (mismatches < 40) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task check_response(logic [spq_pkg::StatusW-1:0] status,
                       logic signed [spq_pkg::DataW-1:0] data,
                       logic signed [spq_pkg::PrioW-1:0] prio,
                       logic [spq_pkg::OccW-1:0] occupancy);
      outcome_type want;
      if (awaited.size() == 0) begin
         report_mismatch("response transaction with no request outstanding");
         return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
         report_mismatch($sformatf("rsp_status got %0d, want %0d", status, want.status));
      end
      if (data !== want.data) begin
         report_mismatch($sformatf("rsp_out_data got %h, want %h", data, want.data));
      end
      if (prio !== want.prio) begin
         report_mismatch($sformatf("rsp_out_priority got %0d, want %0d", prio, want.prio));
      end
      if (occupancy !== want.occupancy) begin
         report_mismatch($sformatf("rsp_occupancy got %0d, want %0d",
                                   occupancy, want.occupancy));
      end
   endtask

endclass

module tb;

   localparam int Depth     = 16;
   localparam int IdleLimit = 2000;
   localparam int Phases    = 19;
   localparam int PhaseLen  = 100;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_action;
   logic signed [spq_pkg::DataW-1:0]  req_item_data;
   logic signed [spq_pkg::PrioW-1:0]  req_item_priority;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [spq_pkg::StatusW-1:0]       rsp_status;
   logic signed [spq_pkg::DataW-1:0]  rsp_out_data;
   logic signed [spq_pkg::PrioW-1:0]  rsp_out_priority;
   logic [spq_pkg::OccW-1:0]          rsp_occupancy;

   priority_queue_checker #(Depth) shadow;
   logic quiet_phase;
   int   stalled_cycles;

   sorted_priority_queue #(.DEPTH(Depth)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic idle_gap();
      while (!quiet_phase && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_item(logic action, logic signed [spq_pkg::DataW-1:0] data,
                            logic signed [spq_pkg::PrioW-1:0] prio);
      idle_gap();
      req_valid         <= 1'b1;
      req_action        <= action;
      req_item_data     <= data;
      req_item_priority <= prio;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(action, data, prio);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [spq_pkg::PrioW-1:0] pick_priority();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom_range(6)) - 3;
         4:          v = $urandom_range(1) ? 32767 : -32768;
         default:    v = int'($urandom);
      endcase
      return v[spq_pkg::PrioW-1:0];
   endfunction

   function automatic logic signed [spq_pkg::DataW-1:0] pick_data();
      if ($urandom_range(19) == 0) begin
         return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      return $urandom;
   endfunction

   // response side: stall at random, check each transaction, watch for hangs
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         shadow.check_response(rsp_status, rsp_out_data, rsp_out_priority, rsp_occupancy);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      rsp_ready <= quiet_phase || ($urandom_range(99) >= 37);
   end

   initial begin
      int enq_pct;
      shadow            = new();
      quiet_phase       = 1'b0;
      stalled_cycles    = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= spq_pkg::ACTION_ENQ;
      req_item_data     <= '0;
      req_item_priority <= '0;
      rsp_ready         <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty pop, extremes, ties at top, bottom and middle, then overflow
      send_item(spq_pkg::ACTION_DEQ, pick_data(), pick_priority());
      send_item(spq_pkg::ACTION_ENQ, 32'sh7FFF_FFFF, 16'sd0);
      send_item(spq_pkg::ACTION_ENQ, 32'sh8000_0000, 16'sh7FFF);
      send_item(spq_pkg::ACTION_ENQ, 32'sh0000_0000, 16'sh8000);
      send_item(spq_pkg::ACTION_ENQ, -32'sd1, -16'sd1);
      send_item(spq_pkg::ACTION_ENQ, 32'sd1, 16'sd5);
      send_item(spq_pkg::ACTION_ENQ, 32'sd2, 16'sd5);
      send_item(spq_pkg::ACTION_ENQ, 32'sd3, 16'sd5);
      send_item(spq_pkg::ACTION_ENQ, 32'sh5555_5555, 16'sh7FFF);
      send_item(spq_pkg::ACTION_ENQ, 32'shAAAA_AAAA, 16'sh8000);
      send_item(spq_pkg::ACTION_ENQ, 32'sd4, 16'sd5);
      send_item(spq_pkg::ACTION_ENQ, 32'sd5, -16'sd1);
      send_item(spq_pkg::ACTION_ENQ, 32'sd6, 16'sd100);
      send_item(spq_pkg::ACTION_ENQ, 32'sd7, -16'sd100);
      send_item(spq_pkg::ACTION_ENQ, 32'sd8, 16'sd0);
      send_item(spq_pkg::ACTION_ENQ, 32'sd9, 16'sd5);
      send_item(spq_pkg::ACTION_ENQ, 32'sd10, 16'sh7FFF);
      send_item(spq_pkg::ACTION_ENQ, 32'sd11, 16'sd1);
      send_item(spq_pkg::ACTION_DEQ, pick_data(), pick_priority());
      send_item(spq_pkg::ACTION_DEQ, pick_data(), pick_priority());
      send_item(spq_pkg::ACTION_DEQ, pick_data(), pick_priority());
      send_item(spq_pkg::ACTION_ENQ, 32'sd12, 16'sh8000);
      drain_wait();

      // cycle through fill, balanced and drain biases
      for (int ph = 0; ph < Phases; ph++) begin
         case (ph % 3)
            0:       enq_pct = 80;
            1:       enq_pct = 50;
            default: enq_pct = 25;
         endcase
         quiet_phase = (ph >= 8 && ph <= 10);
         if (ph == 12) begin
            drain_wait();
         end
         for (int n = 0; n < PhaseLen; n++) begin
            send_item(($urandom_range(99) < enq_pct) ? spq_pkg::ACTION_ENQ
                                                     : spq_pkg::ACTION_DEQ,
                      pick_data(), pick_priority());
         end
      end
      quiet_phase = 1'b0;

      req_valid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
